### rtl/multilevel_priority_request_queue_macros.svh
// Assertion macros used by the queue datapath.
// The clocked form samples on i_clk and is disabled while i_rst_n is low.
`ifndef MULTILEVEL_PRIORITY_REQUEST_QUEUE_MACROS_SVH
`define MULTILEVEL_PRIORITY_REQUEST_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define MPRQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("queue assertion failed");
`define MPRQ_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("queue reset assertion failed");
`else
`define MPRQ_ASSERT(lbl, prop)
`define MPRQ_ASSERT_RST(lbl, prop)
`endif
`endif

### rtl/mprq_pkg.sv
package mprq_pkg;

    localparam int DEPTH  = 32;
    localparam int LEVELS = 5;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int LW  = 3;
    localparam int IDW = 16;
    localparam int TW  = 32;
    localparam int RW  = IDW + LW + TW;

    localparam logic [LW-1:0] LEVEL_NORMAL = LW'(1);
    localparam logic [LW-1:0] LEVEL_TOP    = LW'(LEVELS - 1);

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_CANCEL  = 2'd2;
    localparam logic [1:0] CMD_EXPIRE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_PRIORITY = 2'd1;
    localparam logic [1:0] CFG_EXPIRE   = 2'd2;

    localparam logic [6:0]  RESET_CAPACITY = 7'd32;
    localparam logic [31:0] RESET_EXPIRE   = 32'd30000;

    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_ctrl_stat;

endpackage

### rtl/mprq_ram.sv
module mprq_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mprq_ctrl.sv
module mprq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mprq_pkg::t_ctrl_stat i_stat,
    output mprq_pkg::t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SCAN;
            S_SCAN:  if (i_stat.scan_last) n_state = S_DRAIN;
            S_DRAIN: n_state = S_FIN;
            S_FIN:   if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.start  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.finish = (r_state == S_FIN) && i_stat.out_free;

endmodule

### rtl/mprq_datapath.sv
`include "multilevel_priority_request_queue_macros.svh"

module mprq_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mprq_pkg::t_ctrl_cmd               i_cmd,
    output mprq_pkg::t_ctrl_stat              o_stat,
    input  logic                              i_cfg_valid,
    input  logic [1:0]                        i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    input  logic [1:0]                        i_cmd_code,
    input  logic [mprq_pkg::IDW-1:0]          i_request_id,
    input  logic [mprq_pkg::LW-1:0]           i_priority_level,
    input  logic [mprq_pkg::TW-1:0]           i_now_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status_code,
    output logic [mprq_pkg::IDW-1:0]          o_out_id,
    output logic [mprq_pkg::LW-1:0]           o_out_priority,
    output logic [6:0]                        o_expired_count,
    output logic [6:0]                        o_occupancy
);

    localparam int AW  = mprq_pkg::AW;
    localparam int CW  = mprq_pkg::CW;
    localparam int LW  = mprq_pkg::LW;
    localparam int IDW = mprq_pkg::IDW;
    localparam int TW  = mprq_pkg::TW;
    localparam int D   = mprq_pkg::DEPTH;

    // Configuration registers.
    logic [6:0]  r_cap;
    logic        r_pen;
    logic [31:0] r_exp;

    // Captured command.
    logic [1:0]     r_cmd;
    logic [IDW-1:0] r_id;
    logic [LW-1:0]  r_lvl;
    logic [TW-1:0]  r_now;

    // Slot bookkeeping.
    logic [D-1:0]  r_valid;
    logic [AW-1:0] r_order [D];
    logic [CW-1:0] r_count;

    // Scan state.
    logic [AW-1:0] r_addr;
    logic          r_chk;
    logic [AW-1:0] r_kidx;
    logic          r_found;
    logic [AW-1:0] r_best;
    logic [LW-1:0] r_best_lvl;
    logic [IDW-1:0] r_best_id;
    logic [AW-1:0] r_best_ord;
    logic [6:0]    r_expired;

    // Output register.
    logic           r_o_valid;
    logic [1:0]     r_o_status;
    logic [IDW-1:0] r_o_id;
    logic [LW-1:0]  r_o_prio;
    logic [6:0]     r_o_expired;
    logic [6:0]     r_o_occ;

    logic [mprq_pkg::RW-1:0] w_rdata;
    logic [IDW-1:0] w_k_id;
    logic [LW-1:0]  w_k_lvl;
    logic [TW-1:0]  w_k_stamp;
    logic [AW-1:0]  w_k_ord;
    logic           w_k_valid;
    logic           w_take;
    logic           w_exp_drop;
    logic [6:0]     w_limit;
    logic           w_full;
    logic           w_enq_ok;
    logic           w_fin_drop;
    logic           w_drop;
    logic [AW-1:0]  w_drop_idx;
    logic [AW-1:0]  w_drop_rank;
    logic [LW-1:0]  w_in_lvl;
    logic [1:0]     w_status;
    logic           w_ram_we;

    assign {w_k_id, w_k_lvl, w_k_stamp} = w_rdata;
    assign w_k_ord   = r_order[r_kidx];
    assign w_k_valid = r_valid[r_kidx];

    always_comb begin
        w_in_lvl = i_priority_level;
        if (i_priority_level > mprq_pkg::LEVEL_TOP) begin
            w_in_lvl = mprq_pkg::LEVEL_TOP;
        end
        if (!r_pen) begin
            w_in_lvl = mprq_pkg::LEVEL_NORMAL;
        end
    end

    // Decide whether the slot under inspection replaces the current candidate, or for expire whether it is dropped.
    always_comb begin
        w_take     = 1'b0;
        w_exp_drop = 1'b0;
        case (r_cmd)
            mprq_pkg::CMD_ENQUEUE: w_take = !w_k_valid && !r_found;
            mprq_pkg::CMD_DEQUEUE: begin
                w_take = w_k_valid && (r_pen || w_k_lvl == mprq_pkg::LEVEL_NORMAL) &&
                         (!r_found || w_k_lvl > r_best_lvl ||
                          (w_k_lvl == r_best_lvl && w_k_ord < r_best_ord));
            end
            mprq_pkg::CMD_CANCEL: begin
                w_take = w_k_valid && w_k_id == r_id &&
                         (!r_found || w_k_ord < r_best_ord);
            end
            default: w_exp_drop = w_k_valid && (TW'(r_now - w_k_stamp) > r_exp);
        endcase
        w_take     = w_take && r_chk;
        w_exp_drop = w_exp_drop && r_chk;
    end

    always_comb begin
        w_limit = r_cap;
        if (r_cap == 7'd0 || r_cap > 7'(D)) begin
            w_limit = 7'(D);
        end
    end

    assign w_full     = (7'(r_count) >= w_limit) || !r_found;
    assign w_enq_ok   = (r_cmd == mprq_pkg::CMD_ENQUEUE) && !w_full;
    assign w_fin_drop = i_cmd.finish && r_found &&
                        (r_cmd == mprq_pkg::CMD_DEQUEUE || r_cmd == mprq_pkg::CMD_CANCEL);
    assign w_drop      = w_exp_drop || w_fin_drop;
    assign w_drop_idx  = w_fin_drop ? r_best : r_kidx;
    assign w_drop_rank = w_fin_drop ? r_best_ord : w_k_ord;
    assign w_ram_we    = i_cmd.finish && w_enq_ok;

    always_comb begin
        w_status = mprq_pkg::ST_OK;
        case (r_cmd)
            mprq_pkg::CMD_ENQUEUE: if (w_full) w_status = mprq_pkg::ST_FULL;
            mprq_pkg::CMD_DEQUEUE: if (!r_found) w_status = mprq_pkg::ST_EMPTY;
            mprq_pkg::CMD_CANCEL:  if (!r_found) w_status = mprq_pkg::ST_NOTFOUND;
            default:               w_status = mprq_pkg::ST_OK;
        endcase
    end

    mprq_ram #(.W(mprq_pkg::RW), .D(D)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_best),
        .i_wdata ({r_id, r_lvl, r_now}),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Configuration and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= mprq_pkg::RESET_CAPACITY;
            r_pen     <= 1'b1;
            r_exp     <= mprq_pkg::RESET_EXPIRE;
            r_valid   <= '0;
            r_count   <= '0;
            r_chk     <= 1'b0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mprq_pkg::CFG_CAPACITY: r_cap <= i_cfg_data[6:0];
                    mprq_pkg::CFG_PRIORITY: r_pen <= i_cfg_data[0];
                    mprq_pkg::CFG_EXPIRE:   r_exp <= i_cfg_data;
                    default:                ;
                endcase
            end
            r_chk <= i_cmd.scan;
            if (i_cmd.start) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end
            if (w_drop) begin
                r_valid[w_drop_idx] <= 1'b0;
                r_count <= r_count - CW'(1);
            end else if (w_ram_we) begin
                r_valid[r_best] <= 1'b1;
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.finish) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Arrival ranks close up behind a removed entry; a newly written entry takes the next rank.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < D; k++) begin
            if (w_drop && r_valid[k] && r_order[k] > w_drop_rank) begin
                r_order[k] <= r_order[k] - AW'(1);
            end
        end
        if (w_ram_we) begin
            r_order[r_best] <= r_count[AW-1:0];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cmd     <= i_cmd_code;
            r_id      <= i_request_id;
            r_lvl     <= w_in_lvl;
            r_now     <= i_now_ms;
            r_expired <= '0;
            r_addr    <= '0;
        end else if (i_cmd.scan) begin
            r_addr <= r_addr + AW'(1);
        end
        r_kidx <= r_addr;
        if (w_take) begin
            r_best     <= r_kidx;
            r_best_lvl <= w_k_lvl;
            r_best_id  <= w_k_id;
            r_best_ord <= w_k_ord;
        end
        if (w_exp_drop) begin
            r_expired <= r_expired + 7'd1;
        end
        if (i_cmd.finish) begin
            r_o_status  <= w_status;
            r_o_id      <= (r_cmd == mprq_pkg::CMD_DEQUEUE && r_found) ? r_best_id : '0;
            r_o_prio    <= (r_cmd == mprq_pkg::CMD_DEQUEUE && r_found) ? r_best_lvl : '0;
            r_o_expired <= r_expired;
            r_o_occ     <= w_fin_drop ? 7'(r_count - CW'(1)) :
                           w_ram_we ? 7'(r_count + CW'(1)) : 7'(r_count);
        end
    end

    assign o_stat.scan_last = (r_addr == AW'(D - 1));
    assign o_stat.out_free  = !r_o_valid || i_out_ready;

    assign o_out_valid     = r_o_valid;
    assign o_status_code   = r_o_status;
    assign o_out_id        = r_o_id;
    assign o_out_priority  = r_o_prio;
    assign o_expired_count = r_o_expired;
    assign o_occupancy     = r_o_occ;

    `MPRQ_ASSERT(a_count_matches_valid, ($countones(r_valid) == 32'(r_count)))
    `MPRQ_ASSERT(a_no_finish_during_check, (!(r_chk && i_cmd.finish)))
    `MPRQ_ASSERT(a_enqueue_sets_slot, (w_ram_we |=> r_valid[$past(r_best)]))
    `MPRQ_ASSERT_RST(a_reset_empties, (!i_rst_n |=> (r_count == '0 && !r_o_valid)))

endmodule

### rtl/multilevel_priority_request_queue.sv
// Strict-priority request queue over a 32-slot store. Each accepted item is one
// command (enqueue, dequeue, cancel by id, expire) and yields exactly one result
// item. The controller sweeps the slot RAM one address per cycle through its single
// registered read port, then drains the last read and, in a final state, commits
// the change and loads the output register. No new command is accepted while one
// is in progress. A new item is accepted as soon as the previous result is in the
// output register, even if it is not yet taken. While an older result waits in the
// output register, the next command stops before its commit step. Configuration
// writes are always ready and must only be issued while idle.
module multilevel_priority_request_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_cmd,
    input  logic [mprq_pkg::IDW-1:0]          i_request_id,
    input  logic [mprq_pkg::LW-1:0]           i_priority_level,
    input  logic [mprq_pkg::TW-1:0]           i_now_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status_code,
    output logic [mprq_pkg::IDW-1:0]          o_out_id,
    output logic [mprq_pkg::LW-1:0]           o_out_priority,
    output logic [6:0]                        o_expired_count,
    output logic [6:0]                        o_occupancy,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    mprq_pkg::t_ctrl_cmd  w_cmd;
    mprq_pkg::t_ctrl_stat w_stat;

    mprq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mprq_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd_code       (i_cmd),
        .i_request_id     (i_request_id),
        .i_priority_level (i_priority_level),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status_code    (o_status_code),
        .o_out_id         (o_out_id),
        .o_out_priority   (o_out_priority),
        .o_expired_count  (o_expired_count),
        .o_occupancy      (o_occupancy)
    );

    assign o_cfg_ready = 1'b1;

endmodule

### tb/multilevel_priority_request_queue_checker.sv
`timescale 1ns / 1ps

module multilevel_priority_request_queue_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_request_id,
    input  logic [2:0]  i_priority_level,
    input  logic [31:0] i_now_ms,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status_code,
    input  logic [15:0] i_out_id,
    input  logic [2:0]  i_out_priority,
    input  logic [6:0]  i_expired_count,
    input  logic [6:0]  i_occupancy,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] id;
        logic [2:0]  level;
        logic [6:0]  expired;
        logic [6:0]  occupancy;
    } t_queue_result;

    t_queue_result expected_results[$];

    logic        slot_used [mprq_pkg::DEPTH];
    logic [15:0] slot_id   [mprq_pkg::DEPTH];
    logic [2:0]  slot_level[mprq_pkg::DEPTH];
    logic [31:0] slot_stamp[mprq_pkg::DEPTH];
    int          slot_rank [mprq_pkg::DEPTH];
    int          queued;
    logic [6:0]  cap_limit;
    logic        prio_on;
    logic [31:0] age_limit;

    // Removing a slot closes the gap in the arrival ranks behind it.
    function automatic void remove_slot(input int s);
        for (int k = 0; k < mprq_pkg::DEPTH; k++) begin
            if (slot_used[k] && slot_rank[k] > slot_rank[s]) slot_rank[k]--;
        end
        slot_used[s] = 1'b0;
        queued--;
    endfunction

    function automatic void apply_command(input logic [1:0] cmd, input logic [15:0] rid,
                                          input logic [2:0] lvl, input logic [31:0] now);
        t_queue_result r;
        int best;
        int limit;
        r = '0;
        best = -1;
        r.status = mprq_pkg::ST_OK;
        case (cmd)
            mprq_pkg::CMD_ENQUEUE: begin
                limit = (cap_limit == 0 || cap_limit > mprq_pkg::DEPTH) ?
                        mprq_pkg::DEPTH : int'(cap_limit);
                for (int k = mprq_pkg::DEPTH - 1; k >= 0; k--) if (!slot_used[k]) best = k;
                if (queued >= limit || best < 0) begin
                    r.status = mprq_pkg::ST_FULL;
                end else begin
                    if (lvl > mprq_pkg::LEVEL_TOP) lvl = mprq_pkg::LEVEL_TOP;
                    if (!prio_on) lvl = mprq_pkg::LEVEL_NORMAL;
                    slot_used[best] = 1'b1;
                    slot_id[best] = rid;
                    slot_level[best] = lvl;
                    slot_stamp[best] = now;
                    slot_rank[best] = queued;
                    queued++;
                end
            end
            mprq_pkg::CMD_DEQUEUE: begin
                for (int k = 0; k < mprq_pkg::DEPTH; k++) begin
                    if (slot_used[k] &&
                        (prio_on || slot_level[k] == mprq_pkg::LEVEL_NORMAL)) begin
                        if (best < 0 || slot_level[k] > slot_level[best] ||
                            (slot_level[k] == slot_level[best] &&
                             slot_rank[k] < slot_rank[best])) best = k;
                    end
                end
                if (best < 0) begin
                    r.status = mprq_pkg::ST_EMPTY;
                end else begin
                    r.id = slot_id[best];
                    r.level = slot_level[best];
                    remove_slot(best);
                end
            end
            mprq_pkg::CMD_CANCEL: begin
                for (int k = 0; k < mprq_pkg::DEPTH; k++) begin
                    if (slot_used[k] && slot_id[k] == rid &&
                        (best < 0 || slot_rank[k] < slot_rank[best])) best = k;
                end
                if (best < 0) r.status = mprq_pkg::ST_NOTFOUND;
                else remove_slot(best);
            end
            default: begin
                for (int k = 0; k < mprq_pkg::DEPTH; k++) begin
                    if (slot_used[k] && (now - slot_stamp[k]) > age_limit) begin
                        remove_slot(k);
                        r.expired++;
                    end
                end
            end
        endcase
        r.occupancy = 7'(queued);
        expected_results.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        t_queue_result e;
        if (!i_rst_n) begin
            for (int k = 0; k < mprq_pkg::DEPTH; k++) slot_used[k] = 1'b0;
            queued = 0;
            cap_limit = mprq_pkg::RESET_CAPACITY;
            prio_on = 1'b1;
            age_limit = mprq_pkg::RESET_EXPIRE;
            o_errors = 0;
            o_results = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mprq_pkg::CFG_CAPACITY: cap_limit = i_cfg_data[6:0];
                    mprq_pkg::CFG_PRIORITY: prio_on = i_cfg_data[0];
                    mprq_pkg::CFG_EXPIRE:   age_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected (got %p)", $time,
                             {i_status_code, i_out_id, i_out_priority,
                              i_expired_count, i_occupancy});
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (e.status !== i_status_code || e.id !== i_out_id ||
                        e.level !== i_out_priority || e.expired !== i_expired_count ||
                        e.occupancy !== i_occupancy) begin
                        $display("%0t: mismatch expected st=%0d id=%0h pr=%0d exp=%0d occ=%0d",
                                 $time, e.status, e.id, e.level, e.expired, e.occupancy);
                        $display("%0t:          actual   st=%0d id=%0h pr=%0d exp=%0d occ=%0d",
                                 $time, i_status_code, i_out_id, i_out_priority,
                                 i_expired_count, i_occupancy);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                apply_command(i_cmd, i_request_id, i_priority_level, i_now_ms);
        end
        o_pending = expected_results.size();
    end
endmodule

### tb/multilevel_priority_request_queue_test.sv
`timescale 1ns / 1ps

module multilevel_priority_request_queue_test;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [15:0] request_id;
    logic [2:0]  priority_level;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status_code;
    logic [15:0] out_id;
    logic [2:0]  out_priority;
    logic [6:0]  expired_count;
    logic [6:0]  occupancy;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;
    int          results;
    int          sent;
    logic        hold_off;
    logic [31:0] clock_ms;
    logic [15:0] recent_ids[8];

    multilevel_priority_request_queue dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_cmd(cmd), .i_request_id(request_id),
        .i_priority_level(priority_level), .i_now_ms(now_ms),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_status_code(status_code), .o_out_id(out_id),
        .o_out_priority(out_priority), .o_expired_count(expired_count),
        .o_occupancy(occupancy),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    multilevel_priority_request_queue_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_cmd(cmd), .i_request_id(request_id),
        .i_priority_level(priority_level), .i_now_ms(now_ms),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_status_code(status_code), .i_out_id(out_id),
        .i_out_priority(out_priority), .i_expired_count(expired_count),
        .i_occupancy(occupancy),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #40_000_000;
        $display("** multilevel_priority_request_queue: FAILED **");
        $finish;
    end

    // The receiver stalls on its own pattern; hold_off forces a long stall.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off) out_ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0) out_ready <= 1'b0;
            else out_ready <= ($urandom_range(0, 9) != 0);
        end
    end

    // The item stays offered after acceptance until the caller offers the next
    // one or drops valid for a gap.
    task automatic send_command(input logic [1:0] c, input logic [15:0] rid,
                                input logic [2:0] lvl, input logic [31:0] t);
        in_valid <= 1'b1;
        cmd <= c;
        request_id <= rid;
        priority_level <= lvl;
        now_ms <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Enqueues dominate, cancels often target ids recently queued, and time
    // creeps forward so expire has entries on both sides of the limit.
    task automatic random_phase(input int count);
        int burst;
        int gap;
        logic [1:0] c;
        logic [15:0] rid;
        for (int n = 0; n < count; n++) begin
            if (burst <= 0) begin
                burst = $urandom_range(1, 12);
                gap = $urandom_range(0, 40);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst--;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: c = mprq_pkg::CMD_ENQUEUE;
                5, 6, 7:       c = mprq_pkg::CMD_DEQUEUE;
                8:             c = mprq_pkg::CMD_CANCEL;
                default:       c = mprq_pkg::CMD_EXPIRE;
            endcase
            rid = ($urandom_range(0, 2) == 0) ? 16'($urandom) : recent_ids[$urandom_range(0, 7)];
            if (c == mprq_pkg::CMD_ENQUEUE) recent_ids[$urandom_range(0, 7)] = rid;
            clock_ms = clock_ms + (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3000));
            send_command(c, rid, 3'($urandom), clock_ms);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = mprq_pkg::CMD_ENQUEUE;
        request_id = '0;
        priority_level = '0;
        now_ms = '0;
        cfg_valid = 1'b0;
        cfg_index = mprq_pkg::CFG_CAPACITY;
        cfg_data = '0;
        hold_off = 1'b0;
        sent = 0;
        clock_ms = 32'hFFFF_F000;
        for (int k = 0; k < 8; k++) recent_ids[k] = 16'($urandom);
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty cases, every level, saturated level, duplicates, wrap.
        send_command(mprq_pkg::CMD_DEQUEUE, 16'h0, 3'd0, 32'd0);
        send_command(mprq_pkg::CMD_CANCEL, 16'hFFFF, 3'd0, 32'd0);
        send_command(mprq_pkg::CMD_EXPIRE, 16'h0, 3'd0, 32'd0);
        for (int l = 0; l < 8; l++)
            send_command(mprq_pkg::CMD_ENQUEUE, 16'(l), 3'(l), 32'hFFFF_FF00);
        send_command(mprq_pkg::CMD_ENQUEUE, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
        send_command(mprq_pkg::CMD_ENQUEUE, 16'h0003, 3'd3, 32'd5);
        send_command(mprq_pkg::CMD_CANCEL, 16'h0003, 3'd0, 32'd6);
        send_command(mprq_pkg::CMD_CANCEL, 16'h1234, 3'd0, 32'd6);
        send_command(mprq_pkg::CMD_DEQUEUE, 16'h0, 3'd0, 32'd7);
        send_command(mprq_pkg::CMD_DEQUEUE, 16'h0, 3'd0, 32'd7);
        send_command(mprq_pkg::CMD_EXPIRE, 16'h0, 3'd0, 32'd29_800);
        send_command(mprq_pkg::CMD_EXPIRE, 16'h0, 3'd0, 32'hFFFF_FFFF);

        write_register(mprq_pkg::CFG_PRIORITY, 32'd0);
        send_command(mprq_pkg::CMD_DEQUEUE, 16'h0, 3'd0, 32'd0);
        send_command(mprq_pkg::CMD_ENQUEUE, 16'h00AA, 3'd4, 32'd0);
        send_command(mprq_pkg::CMD_ENQUEUE, 16'h00BB, 3'd1, 32'd0);
        send_command(mprq_pkg::CMD_DEQUEUE, 16'h0, 3'd0, 32'd0);

        // Small capacity and a long receiver stall to back up the input.
        write_register(mprq_pkg::CFG_CAPACITY, 32'd2);
        write_register(mprq_pkg::CFG_EXPIRE, 32'hFFFF_FFFF);
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
            random_phase(60);
        join
        write_register(mprq_pkg::CFG_PRIORITY, 32'd1);
        write_register(mprq_pkg::CFG_CAPACITY, 32'd0);
        write_register(mprq_pkg::CFG_EXPIRE, 32'd0);
        random_phase(80);
        write_register(mprq_pkg::CFG_CAPACITY, 32'd64);
        write_register(mprq_pkg::CFG_EXPIRE, 32'd30000);
        random_phase(160);
        write_register(mprq_pkg::CFG_CAPACITY, 32'd127);
        write_register(mprq_pkg::CFG_PRIORITY, 32'd0);
        random_phase(80);
        write_register(mprq_pkg::CFG_PRIORITY, 32'd1);
        write_register(mprq_pkg::CFG_CAPACITY, 32'd5);
        write_register(mprq_pkg::CFG_EXPIRE, 32'd5000);
        random_phase(120);

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        $display("Ran %0d commands through four command types and several register", sent);
        $display("settings, %0d results checked including a long output stall.", results);
        if (errors == 0 && pending == 0)
            $display("** multilevel_priority_request_queue: PASSED **");
        else
            $display("** multilevel_priority_request_queue: FAILED **");
        $finish;
    end
endmodule
